/* design/kms_pkg.sv */
// ----------------------------------------------------------------------------
// kms_pkg: shared types and constants of the key matrix scanner
// Register map codes, size limits, the configuration bundle and the
// per-word step result.
// ----------------------------------------------------------------------------
`default_nettype none

package kms_pkg;

    // Field widths
    localparam int ROW_W   = 8;    // sensed line levels per sample
    localparam int COL_W   = 3;    // column index
    localparam int COUNT_W = 4;    // line / column counts
    localparam int MAP_W   = 64;   // key bitmap
    localparam int POS_W   = 6;    // bit position inside the bitmap

    // APB register file
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;
    localparam int INDEX_W = 2;

    localparam logic [INDEX_W-1:0] REG_SCAN_ENABLE = 2'd0;
    localparam logic [INDEX_W-1:0] REG_NUM_INPUTS  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_NUM_OUTPUTS = 2'd2;

    // Matrix limits; larger programmed counts are clamped to these
    localparam logic [COUNT_W-1:0] MAX_INPUTS  = 4'd8;
    localparam logic [COUNT_W-1:0] MAX_OUTPUTS = 4'd8;

    // Register reset values
    localparam logic               RST_SCAN_ENABLE = 1'b0;
    localparam logic [COUNT_W-1:0] RST_NUM_INPUTS  = 4'd4;
    localparam logic [COUNT_W-1:0] RST_NUM_OUTPUTS = 4'd3;

    typedef struct packed {
        logic               scan_enable;
        logic [COUNT_W-1:0] num_inputs;
        logic [COUNT_W-1:0] num_outputs;
    } cfg_t;

    typedef struct packed {
        logic [COL_W-1:0] next_column;
        logic             report_valid;
        logic [MAP_W-1:0] key_bitmap;
    } step_result_t;

    // Limit a programmed count to the matrix size
    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                       input logic [COUNT_W-1:0] maxv);
        return (v > maxv) ? maxv : v;
    endfunction

endpackage

`default_nettype wire

/* design/key_matrix_scanner.sv */
// A word is held in the input register, then in the result register; out_stall can hold it in either.
// Throughput: one word per cycle while out_stall is low; the step into the scan state is one
// shallow pass from the input register to the result register.
// Reset (rst_n, async low): scan disabled, 4 lines, 3 columns, column 0,
// scan and stored bitmaps zero, both pipeline registers empty.
// ----------------------------------------------------------------------------
// key_matrix_scanner: key matrix scanner with change report
// Takes one column sample per word, builds the scan bitmap and reports the
// stored bitmap with a flag when a completed scan differs from it.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_scanner
#(
    parameter logic [kms_pkg::COUNT_W-1:0] MAX_INPUTS  = kms_pkg::MAX_INPUTS,
    parameter logic [kms_pkg::COUNT_W-1:0] MAX_OUTPUTS = kms_pkg::MAX_OUTPUTS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kms_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kms_pkg::DATA_W-1:0] pwdata,
    output logic      [kms_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    // sample channel
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [kms_pkg::ROW_W-1:0]  row_levels,
    // result channel
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [kms_pkg::COL_W-1:0]  next_column,
    output logic                            report_valid,
    output logic      [kms_pkg::MAP_W-1:0]  key_bitmap
);
    import kms_pkg::*;

    cfg_t             cfg;
    step_result_t     result;
    logic             in_valid_reg;
    logic [ROW_W-1:0] row_reg;
    logic             out_valid_reg;
    logic [COL_W-1:0] next_column_reg;
    logic             report_valid_reg;
    logic [MAP_W-1:0] key_bitmap_reg;
    logic             in_accept;
    logic             advance;

    kms_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kms_scan_core
    #(
        .MAX_INPUTS  (MAX_INPUTS),
        .MAX_OUTPUTS (MAX_OUTPUTS)
    )
    u_scan_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (advance),
        .row_in  (row_reg),
        .result  (result)
    );

    // Handshake: a word moves on when the result register is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            row_reg <= row_levels;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            next_column_reg  <= result.next_column;
            report_valid_reg <= result.report_valid;
            key_bitmap_reg   <= result.key_bitmap;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_column  = next_column_reg;
    assign report_valid = report_valid_reg;
    assign key_bitmap   = key_bitmap_reg;

endmodule

`default_nettype wire

/* design/kms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// kms_cfg_regs: APB configuration registers
// Holds scan_enable, num_inputs and num_outputs; writes complete in the
// access phase, reads return the register value zero-extended.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_cfg_regs
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [kms_pkg::ADDR_W-1:0] paddr,
    input  wire logic [kms_pkg::DATA_W-1:0] pwdata,
    output logic      [kms_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output kms_pkg::cfg_t                   cfg
);
    import kms_pkg::*;

    logic               scan_enable_reg;
    logic [COUNT_W-1:0] num_inputs_reg;
    logic [COUNT_W-1:0] num_outputs_reg;
    logic [INDEX_W-1:0] reg_index;
    logic               wr_en;

    assign pready    = 1'b1;
    assign reg_index = paddr[ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite && pready;

    // Register writes; an index past the map is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_enable_reg <= RST_SCAN_ENABLE;
            num_inputs_reg  <= RST_NUM_INPUTS;
            num_outputs_reg <= RST_NUM_OUTPUTS;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_SCAN_ENABLE: scan_enable_reg <= pwdata[0];
                REG_NUM_INPUTS:  num_inputs_reg  <= pwdata[COUNT_W-1:0];
                REG_NUM_OUTPUTS: num_outputs_reg <= pwdata[COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_index)
            REG_SCAN_ENABLE: prdata = {{(DATA_W-1){1'b0}}, scan_enable_reg};
            REG_NUM_INPUTS:  prdata = {{(DATA_W-COUNT_W){1'b0}}, num_inputs_reg};
            REG_NUM_OUTPUTS: prdata = {{(DATA_W-COUNT_W){1'b0}}, num_outputs_reg};
            default:         prdata = '0;
        endcase
    end

    assign cfg.scan_enable = scan_enable_reg;
    assign cfg.num_inputs  = num_inputs_reg;
    assign cfg.num_outputs = num_outputs_reg;

endmodule

`default_nettype wire

/* design/kms_scan_core.sv */
// ----------------------------------------------------------------------------
// kms_scan_core: scan state and single-word step logic
// Places one column of line levels into the scan bitmap, closes the scan
// after the last column and updates the stored bitmap on a change.
// ----------------------------------------------------------------------------
`default_nettype none

module kms_scan_core
#(
    parameter logic [kms_pkg::COUNT_W-1:0] MAX_INPUTS  = kms_pkg::MAX_INPUTS,
    parameter logic [kms_pkg::COUNT_W-1:0] MAX_OUTPUTS = kms_pkg::MAX_OUTPUTS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire kms_pkg::cfg_t             cfg,
    input  wire logic                      step_en,
    input  wire logic [kms_pkg::ROW_W-1:0] row_in,
    output kms_pkg::step_result_t          result
);
    import kms_pkg::*;

    logic [COL_W-1:0]   column_reg;
    logic [COL_W-1:0]   column_next;
    logic [MAP_W-1:0]   scan_reg;
    logic [MAP_W-1:0]   scan_next;
    logic [MAP_W-1:0]   stored_reg;
    logic [MAP_W-1:0]   stored_next;
    logic [COUNT_W-1:0] nin;
    logic [COUNT_W-1:0] nout;
    logic [COUNT_W-1:0] column_ext;
    logic               active;
    logic               last_column;
    logic               report;
    logic [MAP_W-1:0]   acc;
    logic [POS_W-1:0]   pos;

    assign nin         = clamp_count(cfg.num_inputs, MAX_INPUTS);
    assign nout        = clamp_count(cfg.num_outputs, MAX_OUTPUTS);
    assign active      = cfg.scan_enable && (nin != '0) && (nout != '0);
    assign column_ext  = {1'b0, column_reg};
    assign last_column = (column_ext + 4'd1) >= nout;

    // Merge this column's levels: line k lands at bit k*nout + column
    always_comb
    begin
        acc = (column_reg == '0) ? '0 : scan_reg;
        pos = '0;
        for (int k = 0; k < ROW_W; k++)
        begin
            pos = POS_W'(POS_W'(k) * {2'b00, nout} + {3'b000, column_reg});
            if ((COUNT_W'(k) < nin) && row_in[k])
            begin
                acc[pos] = 1'b1;
            end
        end
    end

    // Next state
    always_comb
    begin
        column_next = column_reg;
        scan_next   = scan_reg;
        stored_next = stored_reg;
        report      = 1'b0;
        if (active)
        begin
            if (column_ext >= nout)
            begin
                // column went out of range after num_outputs was lowered
                column_next = '0;
                scan_next   = '0;
            end
            else if (last_column)
            begin
                column_next = '0;
                scan_next   = '0;
                if (acc != stored_reg)
                begin
                    stored_next = acc;
                    report      = 1'b1;
                end
            end
            else
            begin
                column_next = column_reg + 3'd1;
                scan_next   = acc;
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            scan_reg   <= '0;
            stored_reg <= '0;
        end
        else if (step_en)
        begin
            column_reg <= column_next;
            scan_reg   <= scan_next;
            stored_reg <= stored_next;
        end
    end

    assign result.next_column  = column_next;
    assign result.report_valid = report;
    assign result.key_bitmap   = stored_next;

endmodule

`default_nettype wire
